>>> src/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on clk and rst_n being visible in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, disabled during reset.
`define AST_IMPLY(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define AST_NEXT(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`endif

>>> src/cptp_pkg.sv
// Shared constants, codes and types for the prime table core.
// No dependencies.
package cptp_pkg;
    localparam int VALUE_BITS  = 20;
    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int DW          = VALUE_BITS + 1;
    localparam int DIV_CNT_W   = $clog2(DW + 1);
    localparam int STATUS_W    = 2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BELOW_ONE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    localparam logic ACT_QUERY  = 1'b0;
    localparam logic ACT_EXTEND = 1'b1;

    typedef struct packed {
        logic          done;
        logic [DW-1:0] quot;
        logic [DW-1:0] rem;
    } div_result_t;
endpackage

>>> src/cached_prime_table_primality_core.sv
// A query inside the table range runs a binary search over the stored primes; other queries
// above one run trial division until sqrt(value); extend runs trial division on each candidate.
// One word at a time: req_stall stays high until the result is in the output register; the shared
// bit-serial divider and the table read port set the pace. rst_n is asynchronous and active low:
// it empties the table and the output register; table contents stay undefined until written.
module cached_prime_table_primality_core
    import cptp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  logic                  action,
    input  logic [VALUE_BITS-1:0] value,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output logic                  prime_flag,
    output logic [STATUS_W-1:0]   status,
    output logic [CNT_W-1:0]      table_count
);
    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_EXT_CHK = 8'b0000_0010,
        S_BS_RD   = 8'b0000_0100,
        S_BS_CMP  = 8'b0000_1000,
        S_TT_NEXT = 8'b0001_0000,
        S_TT_WAIT = 8'b0010_0000,
        S_DIV     = 8'b0100_0000,
        S_OUT     = 8'b1000_0000
    } state_t;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [VALUE_BITS-1:0] last_reg, last_next;
    logic                  act_reg, act_next;
    logic [DW-1:0]         n_reg, n_next;
    logic [VALUE_BITS-1:0] ceil_reg, ceil_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic [DW-1:0]         d_reg, d_next;
    logic [DW-1:0]         dvs_reg, dvs_next;
    logic [CNT_W-1:0]      lo_reg, lo_next;
    logic [CNT_W-1:0]      hi_reg, hi_next;
    logic                  res_flag_reg, res_flag_next;
    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_flag_reg, out_flag_next;
    logic [STATUS_W-1:0]   out_status_reg, out_status_next;
    logic [CNT_W-1:0]      out_count_reg, out_count_next;

    logic                  div_start;
    logic [DW-1:0]         div_divisor;
    div_result_t           div_res;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [VALUE_BITS-1:0] wr_data;
    logic [IDX_W-1:0]      rd_addr;
    logic [VALUE_BITS-1:0] rd_data;
    logic [CNT_W:0]        mid_sum;
    logic [CNT_W-1:0]      mid;
    logic [DW-1:0]         d_start;
    logic                  past_root;
    logic                  is_comp;

    cptp_table_ram u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    cptp_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (n_reg),
        .divisor  (div_divisor),
        .result   (div_res)
    );

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[CNT_W:1];
    // bisection reads at the midpoint, trial division walks the table by index
    assign rd_addr = (state_reg == S_BS_RD) ? mid[IDX_W-1:0] : idx_reg[IDX_W-1:0];
    // integer counting resumes just past the largest stored prime
    assign d_start = (count_reg != '0) ? ({1'b0, last_reg} + DW'(1)) : DW'(2);
    // floor(n/q) < q exactly when q*q > n: no more divisors to try
    assign past_root = div_res.quot < dvs_reg;
    assign is_comp   = !past_root && (div_res.rem == '0);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        last_next       = last_reg;
        act_next        = act_reg;
        n_next          = n_reg;
        ceil_next       = ceil_reg;
        idx_next        = idx_reg;
        d_next          = d_reg;
        dvs_next        = dvs_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        res_flag_next   = res_flag_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        out_flag_next   = out_flag_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        div_start       = 1'b0;
        div_divisor     = d_reg;
        wr_en           = 1'b0;
        wr_addr         = count_reg[IDX_W-1:0];
        wr_data         = n_reg[VALUE_BITS-1:0];

        // drop the output word once taken
        if (out_valid_reg && !rsp_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                res_flag_next   = 1'b0;
                res_status_next = ST_OK;
                if (req_valid)
                begin
                    act_next  = action;
                    ceil_next = value;
                    idx_next  = '0;
                    d_next    = d_start;
                    if (action == ACT_EXTEND)
                    begin
                        if (count_reg == '0)
                        begin
                            if (value < VALUE_BITS'(2))
                            begin
                                state_next = S_OUT;
                            end
                            else
                            begin
                                // seed the table with the first prime
                                wr_en      = 1'b1;
                                wr_addr    = '0;
                                wr_data    = VALUE_BITS'(2);
                                count_next = CNT_W'(1);
                                last_next  = VALUE_BITS'(2);
                                n_next     = DW'(3);
                                state_next = S_EXT_CHK;
                            end
                        end
                        else
                        begin
                            n_next     = {1'b0, last_reg} + DW'(1);
                            state_next = S_EXT_CHK;
                        end
                    end
                    else
                    begin
                        n_next = {1'b0, value};
                        if (value == '0)
                        begin
                            res_status_next = ST_BELOW_ONE;
                            state_next      = S_OUT;
                        end
                        else if (value == VALUE_BITS'(1))
                        begin
                            state_next = S_OUT;
                        end
                        else if ((count_reg != '0) && (value <= last_reg))
                        begin
                            lo_next    = '0;
                            hi_next    = count_reg;
                            state_next = S_BS_RD;
                        end
                        else
                        begin
                            state_next = S_TT_NEXT;
                        end
                    end
                end
            end
            S_EXT_CHK:
            begin
                if (n_reg > {1'b0, ceil_reg})
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    idx_next   = '0;
                    d_next     = d_start;
                    state_next = S_TT_NEXT;
                end
            end
            S_BS_RD:
            begin
                state_next = (lo_reg < hi_reg) ? S_BS_CMP : S_OUT;
            end
            S_BS_CMP:
            begin
                if ({1'b0, rd_data} == n_reg)
                begin
                    res_flag_next = 1'b1;
                    state_next    = S_OUT;
                end
                else
                begin
                    if ({1'b0, rd_data} < n_reg)
                    begin
                        lo_next = mid + CNT_W'(1);
                    end
                    else
                    begin
                        hi_next = mid;
                    end
                    state_next = S_BS_RD;
                end
            end
            S_TT_NEXT:
            begin
                if (idx_reg < count_reg)
                begin
                    state_next = S_TT_WAIT;
                end
                else
                begin
                    div_start   = 1'b1;
                    div_divisor = d_reg;
                    dvs_next    = d_reg;
                    state_next  = S_DIV;
                end
            end
            S_TT_WAIT:
            begin
                div_start   = 1'b1;
                div_divisor = {1'b0, rd_data};
                dvs_next    = {1'b0, rd_data};
                state_next  = S_DIV;
            end
            S_DIV:
            begin
                if (div_res.done)
                begin
                    if (past_root || is_comp)
                    begin
                        if (act_reg == ACT_QUERY)
                        begin
                            res_flag_next = past_root;
                            state_next    = S_OUT;
                        end
                        else if (past_root && (count_reg >= CNT_W'(TABLE_DEPTH)))
                        begin
                            res_status_next = ST_FULL;
                            state_next      = S_OUT;
                        end
                        else
                        begin
                            if (past_root)
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                                last_next  = n_reg[VALUE_BITS-1:0];
                            end
                            n_next     = n_reg + DW'(1);
                            state_next = S_EXT_CHK;
                        end
                    end
                    else
                    begin
                        // advance to the next divisor
                        if (idx_reg < count_reg)
                        begin
                            idx_next = idx_reg + CNT_W'(1);
                        end
                        else
                        begin
                            d_next = d_reg + DW'(1);
                        end
                        state_next = S_TT_NEXT;
                    end
                end
            end
            S_OUT:
            begin
                // hold the result until the output register is free
                if (!out_valid_reg || !rsp_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_flag_next   = res_flag_reg;
                    out_status_next = res_status_reg;
                    out_count_next  = count_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg       <= last_next;
        act_reg        <= act_next;
        n_reg          <= n_next;
        ceil_reg       <= ceil_next;
        idx_reg        <= idx_next;
        d_reg          <= d_next;
        dvs_reg        <= dvs_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        res_flag_reg   <= res_flag_next;
        res_status_reg <= res_status_next;
        out_flag_reg   <= out_flag_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

    assign req_stall   = (state_reg != S_IDLE);
    assign rsp_valid   = out_valid_reg;
    assign prime_flag  = out_flag_reg;
    assign status      = out_status_reg;
    assign table_count = out_count_reg;
endmodule

>>> src/cptp_table_ram.sv
// Prime table storage: one write port, one registered read port.
// Depends on cptp_pkg.
module cptp_table_ram
    import cptp_pkg::*;
(
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [IDX_W-1:0]      wr_addr,
    input  logic [VALUE_BITS-1:0] wr_data,
    input  logic [IDX_W-1:0]      rd_addr,
    output logic [VALUE_BITS-1:0] rd_data
);
    logic [VALUE_BITS-1:0] mem [TABLE_DEPTH];
    logic [VALUE_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
endmodule

>>> src/cptp_divider.sv
// Restoring divider, one quotient bit per cycle.
// Depends on cptp_pkg.
module cptp_divider
    import cptp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output div_result_t   result
);
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DW-1:0]        rem_reg, rem_next;
    logic [DW-1:0]        quo_reg, quo_next;
    logic [DW-1:0]        dvs_reg, dvs_next;
    logic [DW:0]          shifted;
    logic [DW:0]          diff;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[DW-1]};
        diff      = shifted - {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DW);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            // keep the partial remainder when the subtract goes negative
            rem_next = diff[DW] ? shifted[DW-1:0] : diff[DW-1:0];
            quo_next = {quo_reg[DW-2:0], ~diff[DW]};
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign result.done = done_reg;
    assign result.quot = quo_reg;
    assign result.rem  = rem_reg;
endmodule

>>> src/cptp_checker.sv
// Port-level checks for the prime table core, bound to the top level.
// Depends on cptp_pkg and assert_macros.svh.
`include "assert_macros.svh"
module cptp_checker
    import cptp_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  req_valid,
    input logic                  req_stall,
    input logic                  action,
    input logic [VALUE_BITS-1:0] value,
    input logic                  rsp_valid,
    input logic                  rsp_stall,
    input logic                  prime_flag,
    input logic [STATUS_W-1:0]   status,
    input logic [CNT_W-1:0]      table_count
);
    `AST_IMPLY(a_status_code, rsp_valid, status <= ST_FULL)
    `AST_IMPLY(a_prime_ok, rsp_valid && prime_flag, status == ST_OK)
    `AST_IMPLY(a_count_max, rsp_valid, table_count <= CNT_W'(TABLE_DEPTH))
    `AST_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(table_count) && $stable(status))
endmodule

bind cached_prime_table_primality_core cptp_checker u_chk (.*);

>>> tb/sv/testbench.sv
// Self-checking testbench for cached_prime_table_primality_core.
// Depends on cptp_pkg; predicts each result with its own prime table model.
`timescale 1ns / 100ps

module testbench;
    import cptp_pkg::*;

    // Expected contents of one result word.
    typedef struct packed {
        logic                flag;
        logic [STATUS_W-1:0] st;
        logic [CNT_W-1:0]    cnt;
    } rsp_word_t;

    logic                  clk;
    logic                  rst_n;
    logic                  req_valid;
    logic                  req_stall;
    logic                  action;
    logic [VALUE_BITS-1:0] value;
    logic                  rsp_valid;
    logic                  rsp_stall;
    logic                  prime_flag;
    logic [STATUS_W-1:0]   status;
    logic [CNT_W-1:0]      table_count;

    // Mirror of the prime table and its fill level.
    int unsigned primes_seen [TABLE_DEPTH];
    int unsigned num_primes;

    rsp_word_t pending_rsp[$];
    int        mismatches;
    int        words_sent;
    int        words_checked;
    int        gap_pct;     // chance of an idle gap before a request word
    int        stall_pct;   // chance of a response stall in one cycle
    int        stall_hold;

    localparam int unsigned VALUE_MASK = (1 << VALUE_BITS) - 1;
    localparam int unsigned LAST_FILL_PRIME = 8161;  // the 1024th prime

    cached_prime_table_primality_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .action      (action),
        .value       (value),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .prime_flag  (prime_flag),
        .status      (status),
        .table_count (table_count)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Hard stop in case the core hangs.
    initial
    begin
        #2_000_000_000;
        $display("timeout with %0d words still pending", pending_rsp.size());
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Trial division for values beyond the top of the table: first by
    // the stored primes up to the square root, then by consecutive integers.
    function automatic bit divides_out_prime(int unsigned n);
        longint unsigned p;
        longint unsigned d;
        for (int unsigned i = 0; i < num_primes; i++)
        begin
            p = primes_seen[i];
            if (p * p > n)
                return 1'b1;
            if (n % p == 0)
                return 1'b0;
        end
        d = (num_primes > 0) ? longint'(primes_seen[num_primes - 1]) + 1 : 2;
        for (; d * d <= n; d++)
        begin
            if (n % d == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Inside the table range a binary search decides; beyond it, trial division.
    function automatic bit predict_prime_flag(int unsigned n);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        if (n <= 1)
            return 1'b0;
        if (num_primes > 0 && n <= primes_seen[num_primes - 1])
        begin
            lo = 0;
            hi = num_primes;
            while (lo < hi)
            begin
                mid = lo + (hi - lo) / 2;
                if (primes_seen[mid] == n)
                    return 1'b1;
                if (primes_seen[mid] < n)
                    lo = mid + 1;
                else
                    hi = mid;
            end
            return 1'b0;
        end
        return divides_out_prime(n);
    endfunction

    // Grow the mirror up to the ceiling; stop with full status at the first
    // prime that finds no free entry.
    function automatic logic [STATUS_W-1:0] grow_primes_to(int unsigned ceiling);
        int unsigned c;
        if (num_primes == 0)
        begin
            if (ceiling < 2)
                return ST_OK;
            primes_seen[0] = 2;
            num_primes = 1;
        end
        for (c = primes_seen[num_primes - 1] + 1; c <= ceiling; c++)
        begin
            if (divides_out_prime(c))
            begin
                if (num_primes >= TABLE_DEPTH)
                    return ST_FULL;
                primes_seen[num_primes] = c;
                num_primes++;
            end
        end
        return ST_OK;
    endfunction

    function automatic rsp_word_t predict_word(logic act, int unsigned val);
        rsp_word_t w;
        w.flag = 1'b0;
        w.st   = ST_OK;
        if (act == ACT_QUERY)
        begin
            if (val < 1)
                w.st = ST_BELOW_ONE;
            else
                w.flag = predict_prime_flag(val);
        end
        else
            w.st = grow_primes_to(val);
        w.cnt = num_primes[CNT_W-1:0];
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Driving and checking
    // ------------------------------------------------------------------

    // Send one request word. Drive at the falling edge, hold until the core
    // takes it, and predict its result at the accepting edge.
    task automatic send_word(logic act, int unsigned val);
        int gap;
        if ($urandom_range(0, 99) < gap_pct)
        begin
            gap = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 60)
                                                : $urandom_range(1, 4);
            req_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid = 1'b1;
        action    = act;
        value     = val[VALUE_BITS-1:0];
        #1;
        while (req_stall)
        begin
            @(negedge clk);
            #1;
        end
        @(posedge clk);
        pending_rsp.push_back(predict_word(act, val & VALUE_MASK));
        words_sent++;
        @(negedge clk);
        req_valid = 1'b0;
    endtask

    // Hold off new requests until every expected word is back.
    task automatic wait_drained();
        while (pending_rsp.size() != 0)
            @(negedge clk);
        repeat (5) @(negedge clk);
    endtask

    // Random response stalls: mostly short, now and then a long hold.
    always @(negedge clk)
    begin
        if (stall_hold > 0)
        begin
            stall_hold--;
            rsp_stall = 1'b1;
        end
        else if (stall_pct > 0 && $urandom_range(0, 99) < 2)
        begin
            stall_hold = $urandom_range(10, 40);
            rsp_stall = 1'b1;
        end
        else
            rsp_stall = ($urandom_range(0, 99) < stall_pct);
    end

    // Compare each accepted result word with the oldest expectation.
    always @(posedge clk)
    begin
        rsp_word_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: flag %0b status %0d count %0d",
                             prime_flag, status, table_count);
            end
            else
            begin
                want = pending_rsp.pop_front();
                words_checked++;
                if (prime_flag !== want.flag || status !== want.st
                    || table_count !== want.cnt)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("word %0d: expected flag %0b status %0d count %0d, got %0b %0d %0d",
                                 words_checked, want.flag, want.st, want.cnt,
                                 prime_flag, status, table_count);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    function automatic int unsigned top_prime();
        return (num_primes > 0) ? primes_seen[num_primes - 1] : 1;
    endfunction

    // Pick a query value: mostly near the table, some mid-range, a few anywhere.
    function automatic int unsigned pick_query_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(0, top_prime() + 40);
        if (r < 90)
            return $urandom_range(0, 20000);
        return $urandom & VALUE_MASK;
    endfunction

    // Queries and extends on an empty table, then the edge cases.
    task automatic test_directed();
        send_word(ACT_QUERY, 0);         // zero reports below-one
        send_word(ACT_QUERY, 1);         // one is not prime, status ok
        send_word(ACT_QUERY, 2);
        send_word(ACT_QUERY, 3);
        send_word(ACT_QUERY, 4);
        send_word(ACT_QUERY, VALUE_MASK);
        send_word(ACT_QUERY, VALUE_MASK - 2);
        send_word(ACT_EXTEND, 0);        // empty table, ceiling below two
        send_word(ACT_EXTEND, 1);
        send_word(ACT_EXTEND, 2);        // stores the first prime only
        send_word(ACT_EXTEND, 2);        // nothing new
        send_word(ACT_QUERY, 2);
        send_word(ACT_QUERY, 1);
        send_word(ACT_EXTEND, 50);
        send_word(ACT_QUERY, 47);
        send_word(ACT_QUERY, 49);
        send_word(ACT_QUERY, 53);        // just past the table
        send_word(ACT_QUERY, 97);
        send_word(ACT_QUERY, 2809);      // 53 squared, beyond the table
        send_word(ACT_EXTEND, 30);       // ceiling below the top prime
        send_word(ACT_QUERY, 0);
    endtask

    // Grow the table in small steps mixed with queries.
    task automatic test_growth(int n_words);
        int unsigned ceil_v;
        for (int i = 0; i < n_words; i++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                ceil_v = top_prime() + $urandom_range(0, 200);
                if (ceil_v > 8000)
                    ceil_v = $urandom_range(0, 8000);
                send_word(ACT_EXTEND, ceil_v);
            end
            else
                send_word(ACT_QUERY, pick_query_value());
            if (i == n_words / 2)
                wait_drained();
        end
    endtask

    // Fill the table exactly, then overflow it.
    task automatic test_table_full();
        send_word(ACT_EXTEND, LAST_FILL_PRIME);
        send_word(ACT_EXTEND, LAST_FILL_PRIME);     // full but nothing needed
        send_word(ACT_EXTEND, LAST_FILL_PRIME + 50);
        send_word(ACT_EXTEND, VALUE_MASK);
        send_word(ACT_QUERY, LAST_FILL_PRIME);
        send_word(ACT_QUERY, LAST_FILL_PRIME + 6);  // next prime, outside table
    endtask

    // Random traffic against the full table.
    task automatic test_full_random(int n_words);
        for (int i = 0; i < n_words; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_word(ACT_EXTEND, $urandom_range(0, 9000));
            else
                send_word(ACT_QUERY, pick_query_value());
        end
    endtask

    initial
    begin
        int wait_cycles;
        rst_n      = 1'b0;
        req_valid  = 1'b0;
        action     = ACT_QUERY;
        value      = '0;
        rsp_stall  = 1'b0;
        stall_hold = 0;
        stall_pct  = 0;
        gap_pct    = 0;
        num_primes = 0;
        mismatches = 0;
        words_sent = 0;
        words_checked = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        gap_pct   = 30;
        stall_pct = 25;
        test_growth(280);
        gap_pct   = 0;
        stall_pct = 0;
        test_table_full();
        gap_pct   = 40;
        stall_pct = 40;
        test_full_random(300);

        wait_cycles = 0;
        while (pending_rsp.size() != 0 && wait_cycles < 2_000_000)
        begin
            @(negedge clk);
            wait_cycles++;
        end
        repeat (50) @(negedge clk);

        $display("Covered %0d request words, %0d results checked; table grew to %0d primes",
                 words_sent, words_checked, num_primes);
        $display("including empty-table cases, overflow of a full table and wide queries.");
        if (mismatches == 0 && pending_rsp.size() == 0)
            $display("== PASS ==");
        else
        begin
            $display("%0d mismatches, %0d words missing", mismatches, pending_rsp.size());
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
